// File: rtl/bu4_pkg.sv
// ----------------------------------------------------------------------------
// bu4_pkg
// shared types, constants and helpers of the 4x bilinear upscaler
// ----------------------------------------------------------------------------
package bu4_pkg;

  localparam int unsigned PIX_W    = 16;
  localparam int unsigned ROW_W    = 14;
  localparam int unsigned COL_W    = 12;
  localparam int unsigned VAL_W    = 20;
  localparam int unsigned WIDTH_W  = 11;
  localparam int unsigned HEIGHT_W = 13;
  localparam int unsigned YCNT_W   = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QAW      = $clog2(QDEPTH);
  localparam int unsigned WGT_W    = 5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // sample groups caused by one pixel, in output order
  typedef enum logic [3:0] {
    PH_CELL   = 4'b0001,
    PH_RIGHT  = 4'b0010,
    PH_BOTTOM = 4'b0100,
    PH_CORNER = 4'b1000
  } phase_e;

  // work descriptor passed from front to back
  typedef struct packed {
    logic [PIX_W-1:0] a;        // upper left
    logic [PIX_W-1:0] b;        // upper right
    logic [PIX_W-1:0] c;        // lower left
    logic [PIX_W-1:0] d;        // lower right (new pixel)
    logic [3:0]       groups;   // bit set per phase_e code
    logic [ROW_W-1:0] base_row; // 4*(y-1)
    logic [COL_W-1:0] base_col; // 4*(x-1)
  } desc_t;

  function automatic phase_e first_phase(logic [3:0] groups);
    phase_e ph;
    if (groups[0]) ph = PH_CELL;
    else if (groups[1]) ph = PH_RIGHT;
    else if (groups[2]) ph = PH_BOTTOM;
    else ph = PH_CORNER;
    return ph;
  endfunction

  // product of two quarter offsets, each 0..4
  function automatic logic [WGT_W-1:0] weight(logic [2:0] p, logic [2:0] q);
    logic [5:0] prod;
    prod = {3'b000, p} * {3'b000, q};
    return prod[WGT_W-1:0];
  endfunction

endpackage

// File: rtl/bilinear_upscale_by_four_unit.sv
// ----------------------------------------------------------------------------
// bilinear_upscale_by_four_unit
// 4x bilinear upscaler for raster images, samples exact in sixteenths
// ----------------------------------------------------------------------------
// Pixels of a W by H frame enter in raster order through a queue-like push
// port and the (4W-3) by (4H-3) interpolated grid leaves through a pop port,
// each sample tagged with its output row and column. Pixel (x,y) with x and y
// at least 1 yields the 16 samples of the cell above and to the left; the
// last column adds 4 right-edge samples, the last row 4 bottom-edge samples,
// and the last pixel of the frame the final corner; last_of_run_o marks the
// final sample caused by a pixel. Rate: the input takes one pixel a cycle as
// long as the 4-entry descriptor queue has room; the output sequencer emits
// one sample a cycle while its output register is free or popped. A pixel
// causes 16 samples if interior, 20 at the right or bottom edge, up to 25 at
// the final corner, none on the first row or column unless also the last.
// A pixel's first sample is registered in the front, the queue, the back
// and the output register. Writing either size register restarts the frame at
// pixel (0,0); write only while the block is idle. The row store needs no
// clearing after reset.
// ----------------------------------------------------------------------------
module bilinear_upscale_by_four_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bu4_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bu4_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // pixel input
  input  logic                            push,
  output logic                            full,
  input  logic [bu4_pkg::PIX_W-1:0]       pixel_value_i,
  // sample output
  output logic                            empty,
  input  logic                            pop,
  output logic [bu4_pkg::ROW_W-1:0]       out_row_o,
  output logic [bu4_pkg::COL_W-1:0]       out_col_o,
  output logic [bu4_pkg::VAL_W-1:0]       sample_value_o,
  output logic                            last_of_run_o
);

  // descriptor hand-off between front and back
  logic           fq_push;
  bu4_pkg::desc_t fq_desc;
  logic           fq_full;
  logic           qb_valid;
  bu4_pkg::desc_t qb_desc;
  logic           qb_pop;

  // front: size registers, raster counters, row store, cell corners
  bu4_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .push_i        (push),
    .full_o        (full),
    .pixel_value_i (pixel_value_i),
    .q_push_o      (fq_push),
    .q_desc_o      (fq_desc),
    .q_full_i      (fq_full)
  );

  // queue of pending pixels that still owe samples
  bu4_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .desc_i  (fq_desc),
    .full_o  (fq_full),
    .valid_o (qb_valid),
    .desc_o  (qb_desc),
    .pop_i   (qb_pop)
  );

  // back: walks the sample groups, one sample per cycle while the output register is free
  bu4_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (qb_valid),
    .q_desc_i       (qb_desc),
    .q_pop_o        (qb_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .sample_value_o (sample_value_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

// File: rtl/bu4_front.sv
// ----------------------------------------------------------------------------
// bu4_front
// config registers, raster position, row store and cell assembly
// ----------------------------------------------------------------------------
module bu4_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bu4_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bu4_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                push_i,
  output logic                                full_o,
  input  logic [bu4_pkg::PIX_W-1:0]           pixel_value_i,
  output logic                                q_push_o,
  output bu4_pkg::desc_t                      q_desc_o,
  input  logic                                q_full_i
);

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam logic [bu4_pkg::PIX_W-1:0] PIX_MASK = (PIXEL_BITS >= bu4_pkg::PIX_W) ?
      {bu4_pkg::PIX_W{1'b1}} : bu4_pkg::PIX_W'((64'd1 << PIXEL_BITS) - 64'd1);
  localparam logic [13:0] MW = 14'(MAX_WIDTH);

  logic [bu4_pkg::WIDTH_W-1:0]  width_q;
  logic [bu4_pkg::HEIGHT_W-1:0] height_q;
  logic [XW-1:0]                x_q;
  logic [bu4_pkg::YCNT_W-1:0]   y_q;
  logic [XW-1:0]                w_last;
  logic [bu4_pkg::YCNT_W-1:0]   h_last;
  logic [13:0]                  w_raw;
  logic                         accept;
  logic                         advance;
  logic                         cfg_hit;
  logic [bu4_pkg::PIX_W-1:0]    pix;

  logic [bu4_pkg::PIX_W-1:0]    mem [MAX_WIDTH];
  logic [bu4_pkg::PIX_W-1:0]    rd_q;

  logic                         s1_valid_q;
  logic [bu4_pkg::PIX_W-1:0]    s1_d_q;
  logic [3:0]                   s1_groups_q;
  logic [bu4_pkg::ROW_W-1:0]    s1_row_q;
  logic [bu4_pkg::COL_W-1:0]    s1_col_q;
  logic [bu4_pkg::PIX_W-1:0]    ul_q;
  logic [bu4_pkg::PIX_W-1:0]    left_q;

  logic [3:0]                   groups;
  logic                         x_first;
  logic                         y_first;
  logic                         x_end;
  logic                         y_end;

  assign cfg_ready_o = 1'b1;
  assign cfg_hit = cfg_valid_i &&
                   (cfg_index_i == bu4_pkg::REG_IMAGE_WIDTH ||
                    cfg_index_i == bu4_pkg::REG_IMAGE_HEIGHT);

  // clamp the frame size
  assign w_raw = 14'(width_q);
  always_comb begin
    if (width_q == '0) begin
      w_last = '0;
    end else if (w_raw > MW) begin
      w_last = XW'(MAX_WIDTH - 1);
    end else begin
      w_last = XW'(w_raw - 14'd1);
    end
    if (height_q == '0) begin
      h_last = '0;
    end else if (height_q > 13'd4096) begin
      h_last = 12'd4095;
    end else begin
      h_last = 12'(height_q - 13'd1);
    end
  end

  assign advance = s1_valid_q && !q_full_i;
  assign full_o  = s1_valid_q && q_full_i;
  assign accept  = push_i && !full_o;
  assign pix     = pixel_value_i & PIX_MASK;

  assign x_first = (x_q == '0);
  assign y_first = (y_q == '0);
  assign x_end   = (x_q == w_last);
  assign y_end   = (y_q == h_last);
  assign groups  = {x_end && y_end, y_end && !x_first, x_end && !y_first,
                    !x_first && !y_first};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd1024;
      height_q <= 13'd4096;
      x_q      <= '0;
      y_q      <= '0;
    end else if (cfg_hit) begin
      if (cfg_index_i == bu4_pkg::REG_IMAGE_WIDTH) begin
        width_q <= cfg_data_i[bu4_pkg::WIDTH_W-1:0];
      end else begin
        height_q <= cfg_data_i;
      end
      x_q <= '0;
      y_q <= '0;
    end else if (accept) begin
      if (x_end) begin
        x_q <= '0;
        y_q <= y_end ? '0 : y_q + 12'd1;
      end else begin
        x_q <= x_q + XW'(1);
      end
    end
  end

  // row store: old entry out, new pixel in
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q   <= mem[x_q];
      mem[x_q] <= pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      ul_q       <= '0;
      left_q     <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        ul_q   <= rd_q;
        left_q <= s1_d_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_d_q      <= pix;
      s1_groups_q <= groups;
      s1_row_q    <= bu4_pkg::ROW_W'({y_q, 2'b00}) - 14'd4;
      s1_col_q    <= bu4_pkg::COL_W'({x_q, 2'b00}) - 12'd4;
    end
  end

  // upper corners only count once a row lies above
  assign q_push_o          = advance && (s1_groups_q != '0);
  assign q_desc_o.a        = ((s1_groups_q & 4'(bu4_pkg::PH_CELL)) != '0) ? ul_q : '0;
  assign q_desc_o.b        =
      ((s1_groups_q & 4'(bu4_pkg::PH_CELL | bu4_pkg::PH_RIGHT)) != '0) ? rd_q : '0;
  assign q_desc_o.c        = left_q;
  assign q_desc_o.d        = s1_d_q;
  assign q_desc_o.groups   = s1_groups_q;
  assign q_desc_o.base_row = s1_row_q;
  assign q_desc_o.base_col = s1_col_q;

endmodule

// File: rtl/bu4_queue.sv
// ----------------------------------------------------------------------------
// bu4_queue
// small descriptor fifo between front and back
// ----------------------------------------------------------------------------
module bu4_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bu4_pkg::desc_t desc_i,
  output logic           full_o,
  output logic           valid_o,
  output bu4_pkg::desc_t desc_o,
  input  logic           pop_i
);

  bu4_pkg::desc_t             entry_q [bu4_pkg::QDEPTH];
  logic [bu4_pkg::QAW-1:0]    wr_ptr_q;
  logic [bu4_pkg::QAW-1:0]    rd_ptr_q;
  logic [bu4_pkg::QAW:0]      count_q;
  logic                       do_push;
  logic                       do_pop;

  assign full_o  = (count_q == (bu4_pkg::QAW+1)'(bu4_pkg::QDEPTH));
  assign valid_o = (count_q != '0);
  assign desc_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + bu4_pkg::QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + bu4_pkg::QAW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + (bu4_pkg::QAW+1)'(1);
        2'b01:   count_q <= count_q - (bu4_pkg::QAW+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: rtl/bu4_back.sv
// ----------------------------------------------------------------------------
// bu4_back
// sample sequencer: one interpolated sample per cycle, while the output is free or popped, into the output register
// ----------------------------------------------------------------------------
module bu4_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  bu4_pkg::desc_t               q_desc_i,
  output logic                         q_pop_o,
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic [bu4_pkg::ROW_W-1:0]    out_row_o,
  output logic [bu4_pkg::COL_W-1:0]    out_col_o,
  output logic [bu4_pkg::VAL_W-1:0]    sample_value_o,
  output logic                         last_of_run_o
);

  localparam int unsigned SUM_W = bu4_pkg::PIX_W + bu4_pkg::WGT_W + 2;

  bu4_pkg::desc_t  desc_q;
  bu4_pkg::phase_e phase_q;
  logic [3:0]      rem_q;
  logic [3:0]      cnt_q;
  logic            busy_q;
  logic            out_valid_q;

  logic [2:0]      r;
  logic [2:0]      k;
  logic            phase_end;
  logic            out_rdy;
  logic            step;
  logic            last;
  logic            load;
  logic [3:0]      first_bits;
  logic [SUM_W-1:0] sum;

  always_comb begin
    case (phase_q)
      bu4_pkg::PH_CELL: begin
        r = {1'b0, cnt_q[3:2]};
        k = {1'b0, cnt_q[1:0]};
        phase_end = (cnt_q == 4'd15);
      end
      bu4_pkg::PH_RIGHT: begin
        r = {1'b0, cnt_q[1:0]};
        k = 3'd4;
        phase_end = (cnt_q[1:0] == 2'd3);
      end
      bu4_pkg::PH_BOTTOM: begin
        r = 3'd4;
        k = {1'b0, cnt_q[1:0]};
        phase_end = (cnt_q[1:0] == 2'd3);
      end
      bu4_pkg::PH_CORNER: begin
        r = 3'd4;
        k = 3'd4;
        phase_end = 1'b1;
      end
      default: begin
        r = 3'd0;
        k = 3'd0;
        phase_end = 1'b1;
      end
    endcase
  end

  assign out_rdy = !out_valid_q || pop_i;
  assign step    = busy_q && out_rdy;
  assign last    = step && phase_end && (rem_q == '0);
  assign load    = q_valid_i && (!busy_q || last);
  assign q_pop_o = load;
  assign first_bits = bu4_pkg::first_phase(q_desc_i.groups);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= bu4_pkg::PH_CELL;
      rem_q   <= '0;
      cnt_q   <= '0;
    end else if (load) begin
      busy_q  <= 1'b1;
      phase_q <= bu4_pkg::first_phase(q_desc_i.groups);
      rem_q   <= q_desc_i.groups & ~first_bits;
      cnt_q   <= '0;
    end else if (last) begin
      busy_q <= 1'b0;
    end else if (step) begin
      if (phase_end) begin
        phase_q <= bu4_pkg::first_phase(rem_q);
        rem_q   <= rem_q & ~4'(bu4_pkg::first_phase(rem_q));
        cnt_q   <= '0;
      end else begin
        cnt_q <= cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      desc_q <= q_desc_i;
    end
  end

  // (4-r)(4-k)a + (4-r)k b + r(4-k)c + rk d
  assign sum = SUM_W'(desc_q.a) * SUM_W'(bu4_pkg::weight(3'd4 - r, 3'd4 - k))
             + SUM_W'(desc_q.b) * SUM_W'(bu4_pkg::weight(3'd4 - r, k))
             + SUM_W'(desc_q.c) * SUM_W'(bu4_pkg::weight(r, 3'd4 - k))
             + SUM_W'(desc_q.d) * SUM_W'(bu4_pkg::weight(r, k));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_row_o      <= desc_q.base_row + bu4_pkg::ROW_W'(r);
      out_col_o      <= desc_q.base_col + bu4_pkg::COL_W'(k);
      sample_value_o <= sum[bu4_pkg::VAL_W-1:0];
      last_of_run_o  <= phase_end && (rem_q == '0);
    end
  end

  assign empty_o = !out_valid_q;

  a_rem_after_current: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ((rem_q & 4'(phase_q)) == '0))
    else $error("pending groups include the current one");

  a_corner_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && phase_q == bu4_pkg::PH_CORNER) |-> (rem_q == '0))
    else $error("groups pending after corner sample");

  a_bottom_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && phase_q == bu4_pkg::PH_BOTTOM) |-> (!rem_q[0] && !rem_q[1]))
    else $error("cell or right edge pending during bottom edge");

endmodule
